[src/lidp_pkg.sv]
package lidp_pkg;

    // Packet geometry and angle constants.
    localparam int SAMPLES_PER_PACKET = 40;
    localparam int IDX_W = 6;
    localparam int FULL_TURN_Q6 = 23040;

    // Result kind codes.
    localparam logic RESULT_DIST  = 1'b0;
    localparam logic RESULT_ANGLE = 1'b1;

    // One result item as it leaves the block.
    typedef struct packed {
        logic        kind;
        logic [15:0] distance;
        logic [14:0] angle;
        logic        sweep;
        logic        pend;
        logic        ok;
        logic        last;
    } result_t;

    // Request from the parser to start an angle burst.
    typedef struct packed {
        logic               start;
        logic [14:0]        prev_angle;
        logic signed [16:0] diff;
        logic               sweep;
    } burst_req_t;

endpackage

[src/lidp_parser.sv]
module lidp_parser
    import lidp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output logic       dist_valid,
    output result_t    dist_res,
    output burst_req_t burst
);

    localparam logic [2:0] PH_SYNC_A = 3'd0;
    localparam logic [2:0] PH_SYNC_5 = 3'd1;
    localparam logic [2:0] PH_ANG_LO = 3'd2;
    localparam logic [2:0] PH_ANG_HI = 3'd3;
    localparam logic [2:0] PH_DST_LO = 3'd4;
    localparam logic [2:0] PH_DST_HI = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       check_reg, check_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       low_reg, low_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [14:0]      angle_reg, angle_next;
    logic             first_reg, first_next;
    logic             good_reg, good_next;
    logic             sweep_reg, sweep_next;

    logic [3:0]         hi_nib;
    logic [3:0]         lo_nib;
    logic [7:0]         xor_upd;
    logic signed [16:0] raw_diff;
    logic               pend;

    assign hi_nib  = rx_byte[7:4];
    assign lo_nib  = rx_byte[3:0];
    assign xor_upd = xor_reg ^ rx_byte;
    assign pend    = (idx_reg >= IDX_W'(SAMPLES_PER_PACKET - 1));

    // Angle step between the held start angle and the arriving one.
    assign raw_diff = $signed({2'b00, rx_byte[6:0], low_reg})
                      - $signed({2'b00, angle_reg});

    // Next-state and result logic for one byte.
    always_comb
    begin
        phase_next = phase_reg;
        check_next = check_reg;
        xor_next   = xor_reg;
        low_next   = low_reg;
        idx_next   = idx_reg;
        angle_next = angle_reg;
        first_next = first_reg;
        good_next  = good_reg;
        sweep_next = sweep_reg;

        dist_valid          = 1'b0;
        dist_res.kind       = RESULT_DIST;
        dist_res.distance   = {rx_byte, low_reg};
        dist_res.angle      = '0;
        dist_res.sweep      = sweep_reg;
        dist_res.pend       = pend;
        dist_res.ok         = pend && (xor_upd == check_reg);
        dist_res.last       = 1'b1;

        burst.start      = 1'b0;
        burst.prev_angle = angle_reg;
        burst.sweep      = sweep_reg;
        if (raw_diff < 0)
        begin
            burst.diff = raw_diff + 17'sd23040;
        end
        else
        begin
            burst.diff = raw_diff;
        end

        unique case (phase_reg)
            PH_SYNC_5:
            begin
                if (hi_nib == 4'h5)
                begin
                    check_next = {lo_nib, check_reg[3:0]};
                    phase_next = PH_ANG_LO;
                end
                else
                begin
                    check_next = '0;
                    phase_next = PH_SYNC_A;
                end
            end
            PH_ANG_LO:
            begin
                xor_next   = rx_byte;
                low_next   = rx_byte;
                phase_next = PH_ANG_HI;
            end
            PH_ANG_HI:
            begin
                xor_next   = xor_upd;
                angle_next = {rx_byte[6:0], low_reg};
                sweep_next = rx_byte[7];
                if (first_reg || !good_reg)
                begin
                    first_next = 1'b0;
                end
                else
                begin
                    burst.start = 1'b1;
                end
                idx_next   = '0;
                phase_next = PH_DST_LO;
            end
            PH_DST_LO:
            begin
                low_next   = rx_byte;
                xor_next   = xor_upd;
                phase_next = PH_DST_HI;
            end
            PH_DST_HI:
            begin
                xor_next   = xor_upd;
                dist_valid = 1'b1;
                if (pend)
                begin
                    good_next  = (xor_upd == check_reg);
                    phase_next = PH_SYNC_A;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    phase_next = PH_DST_LO;
                end
            end
            default:
            begin
                // Hunting for the first sync byte; unused codes land here too.
                if (hi_nib == 4'hA)
                begin
                    check_next = {4'h0, lo_nib};
                    phase_next = PH_SYNC_5;
                end
                else
                begin
                    phase_next = PH_SYNC_A;
                end
            end
        endcase
    end

    // Parser state advances only when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC_A;
            check_reg <= '0;
            xor_reg   <= '0;
            low_reg   <= '0;
            idx_reg   <= '0;
            angle_reg <= '0;
            first_reg <= 1'b1;
            good_reg  <= 1'b0;
            sweep_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            check_reg <= check_next;
            xor_reg   <= xor_next;
            low_reg   <= low_next;
            idx_reg   <= idx_next;
            angle_reg <= angle_next;
            first_reg <= first_next;
            good_reg  <= good_next;
            sweep_reg <= sweep_next;
        end
    end

endmodule

[src/lidp_interp.sv]
module lidp_interp
    import lidp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_req_t req,
    input  logic       take,
    output logic       busy,
    output logic       emit,
    output result_t    res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;
    localparam logic [1:0] ST_RUN   = 2'd3;

    localparam int RECIP_SHIFT = 21;
    localparam logic [21:0] RECIP =
        22'((2 ** RECIP_SHIFT + SAMPLES_PER_PACKET - 1) / SAMPLES_PER_PACKET);

    logic [1:0]         state_reg, state_next;
    logic [14:0]        mag_reg;
    logic               neg_reg;
    logic [14:0]        prev_reg;
    logic               sweep_reg;
    logic [14:0]        qm_reg;
    logic signed [16:0] qd_reg;
    logic [IDX_W-1:0]   rd_reg;
    logic signed [16:0] acc_q_reg;
    logic [IDX_W-1:0]   acc_r_reg;
    logic [IDX_W-1:0]   j_reg;

    logic [36:0]        prod;
    logic [20:0]        qn;
    logic [14:0]        rem_full;
    logic [IDX_W-1:0]   rm;
    logic signed [16:0] qd_calc;
    logic [IDX_W-1:0]   rd_calc;
    logic [IDX_W:0]     r_sum;
    logic signed [17:0] a_raw;
    logic signed [17:0] a_fix;
    logic               is_last;

    // Magnitude of the step divided by the sample count, by reciprocal.
    assign prod = 37'(mag_reg) * 37'(RECIP);

    // Split the quotient into floor quotient and remainder of the signed step.
    assign qn       = 21'(qm_reg) * 21'(SAMPLES_PER_PACKET);
    assign rem_full = mag_reg - qn[14:0];
    assign rm       = rem_full[IDX_W-1:0];

    always_comb
    begin
        if (neg_reg && (rm != '0))
        begin
            qd_calc = -$signed({2'b00, qm_reg}) - 17'sd1;
            rd_calc = IDX_W'(SAMPLES_PER_PACKET) - rm;
        end
        else if (neg_reg)
        begin
            qd_calc = -$signed({2'b00, qm_reg});
            rd_calc = '0;
        end
        else
        begin
            qd_calc = $signed({2'b00, qm_reg});
            rd_calc = rm;
        end
    end

    // Current interpolated angle, folded back into one turn.
    assign a_raw = $signed({3'b000, prev_reg}) + $signed({acc_q_reg[16], acc_q_reg});
    always_comb
    begin
        if (a_raw > 18'sd23040)
        begin
            a_fix = a_raw - 18'sd23040;
        end
        else
        begin
            a_fix = a_raw;
        end
    end

    assign r_sum   = {1'b0, acc_r_reg} + {1'b0, rd_reg};
    assign is_last = (j_reg == IDX_W'(SAMPLES_PER_PACKET - 1));

    assign busy = (state_reg != ST_IDLE);
    assign emit = (state_reg == ST_RUN);

    always_comb
    begin
        res.kind     = RESULT_ANGLE;
        res.distance = '0;
        res.angle    = a_fix[14:0];
        res.sweep    = sweep_reg;
        res.pend     = 1'b0;
        res.ok       = 1'b0;
        res.last     = is_last;
    end

    // Burst sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                if (take && is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers of the burst.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && load)
        begin
            prev_reg  <= req.prev_angle;
            sweep_reg <= req.sweep;
            neg_reg   <= req.diff[16];
            if (req.diff[16])
            begin
                mag_reg <= 15'(-req.diff);
            end
            else
            begin
                mag_reg <= req.diff[14:0];
            end
        end
        if (state_reg == ST_DIV)
        begin
            qm_reg <= prod[RECIP_SHIFT+14:RECIP_SHIFT];
        end
        if (state_reg == ST_SPLIT)
        begin
            qd_reg    <= qd_calc;
            rd_reg    <= rd_calc;
            acc_q_reg <= '0;
            acc_r_reg <= '0;
            j_reg     <= '0;
        end
        if ((state_reg == ST_RUN) && take)
        begin
            j_reg <= j_reg + 1'b1;
            if (r_sum >= (IDX_W + 1)'(SAMPLES_PER_PACKET))
            begin
                acc_r_reg <= IDX_W'(r_sum - (IDX_W + 1)'(SAMPLES_PER_PACKET));
                acc_q_reg <= acc_q_reg + qd_reg + 17'sd1;
            end
            else
            begin
                acc_r_reg <= r_sum[IDX_W-1:0];
                acc_q_reg <= acc_q_reg + qd_reg;
            end
        end
    end

endmodule

[src/lidar_dense_packet_decoder.sv]
// Dense express-scan lidar packet decoder.
// Input channel: in_valid/in_ready with rx_byte, one serial byte per transfer.
// Output channel: out_valid/out_ready with result_kind, distance_mm, angle_q6,
// new_sweep, packet_end, checksum_ok and last, one result per transfer.
// A byte waits in the input register until it is consumed, and its result is
// then written into the output register, where a distance becomes visible.
// One byte is taken per cycle while the receiver keeps up and no angle burst
// runs; the input register and output register let a new byte enter while a
// finished result still waits.
// A start-angle byte that follows a good packet starts an angle burst: setup
// in the DIV and SPLIT states of the interpolation divider, then 40 angle
// results, one per cycle while the receiver takes them; input stalls for the
// burst, which uses a reciprocal multiply and a per-sample accumulator.
// When the receiver holds out_ready low, the output register keeps its
// result, the burst and parser pause, and in_ready falls once the input
// register is full. Reset clears the parser to the sync hunt, marks the next
// packet as the first one and empties both registers.
module lidar_dense_packet_decoder
    import lidp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [15:0] distance_mm,
    output logic [14:0] angle_q6,
    output logic        new_sweep,
    output logic        packet_end,
    output logic        checksum_ok,
    output logic        last
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       slot_free;
    logic       fire;
    logic       dist_valid;
    result_t    dist_res;
    burst_req_t burst;
    logic       busy;
    logic       emit;
    result_t    burst_res;

    assign slot_free = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && !busy && slot_free;
    assign in_ready  = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    lidp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .rx_byte    (byte_reg),
        .dist_valid (dist_valid),
        .dist_res   (dist_res),
        .burst      (burst)
    );

    lidp_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire && burst.start),
        .req   (burst),
        .take  (slot_free),
        .busy  (busy),
        .emit  (emit),
        .res   (burst_res)
    );

    // Output register: a distance from the parser or an angle from the burst.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && dist_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (emit && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && dist_valid)
        begin
            out_reg <= dist_res;
        end
        else if (emit && slot_free)
        begin
            out_reg <= burst_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_reg.kind;
    assign distance_mm = out_reg.distance;
    assign angle_q6    = out_reg.angle;
    assign new_sweep   = out_reg.sweep;
    assign packet_end  = out_reg.pend;
    assign checksum_ok = out_reg.ok;
    assign last        = out_reg.last;

endmodule
